[hw/rtl/dss_pkg.sv]
// Package for the delimiter stream splitter: register indexes, reset values,
// the job control struct and the result struct shared by the core modules.
// No dependencies.
`default_nettype none

package dss_pkg;

	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 1;
	localparam int DLEN_W     = 4;
	localparam int CNT32_W    = 32;

	localparam logic [CFG_IDX_W-1:0] REG_DELIM_VALUE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = 1'b1;

	localparam logic [CFG_DATA_W-1:0] DELIM_VALUE_RST  = 64'd10;
	localparam logic [DLEN_W-1:0]     DELIM_LENGTH_RST = 4'd1;

	// control part of one decoded input transaction
	typedef struct packed {
		logic nonempty;  // at least one result follows
		logic match;     // delimiter matched: one piece end after the bytes
		logic last;      // end of stream: one more piece end at the tail
	} dss_job_t;

	typedef struct packed {
		logic [CNT32_W-1:0] delimiters_seen;
		logic [CNT32_W-1:0] bytes_returned;
		logic [CNT32_W-1:0] pieces_returned;
		logic               piece_end;
		logic               byte_valid;
		logic [7:0]         out_byte;
	} dss_res_t;

endpackage

`default_nettype wire

[hw/rtl/delimiter_stream_splitter_core.sv]
// Top level of the delimiter stream splitter: configuration registers,
// stream ports and the window / result sequencer pair.
// Depends on dss_pkg, dss_window and dss_emit.
//
//  channel  dir  handshake          payload
//  cfg      in   cfg_wr_en          cfg_index (0 value, 1 length), cfg_data
//  s        in   s_tvalid/s_tready  tdata: data_byte; tuser: has_byte; tlast: stream_last
//  m        out  m_tvalid/m_tready  tdata: out_byte, counters; tuser: byte_valid; tlast: piece_end
//
// An input transaction is decoded in the cycle it is accepted; its results then leave one per
// cycle from the output register while m_tready is high, so a transaction with k results
// (k is 0 to MAX_DELIM_LEN+1) holds s_tready low until its last result leaves, set by the
// single result port of the sequencer. One-result transactions stream at one per cycle while
// m_tready is high. Reset clears the window, the counters and the output valid, and loads
// the delimiter (newline, length 1). A stall on m_tready holds the result register.
`default_nettype none

module delimiter_stream_splitter_core import dss_pkg::*; #(
	parameter int MAX_DELIM_LEN = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,   // data_byte
	input  wire logic                  s_tuser,   // has_byte
	input  wire logic                  s_tlast,   // stream_last
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// out_byte[7:0], pieces_returned[39:8], bytes_returned[71:40],
	// delimiters_seen[103:72]
	output logic [103:0]               m_tdata,
	output logic                       m_tuser,   // byte_valid
	output logic                       m_tlast    // piece_end
);

	localparam int CNT_W = $clog2(MAX_DELIM_LEN + 1);

	logic [CFG_DATA_W-1:0] delim_value_q;
	logic [DLEN_W-1:0]     delim_length_q;

	logic             accept;
	logic [7:0]       job_bytes [MAX_DELIM_LEN];
	logic [CNT_W-1:0] job_nb;
	dss_job_t         job;
	dss_res_t         res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_value_q  <= DELIM_VALUE_RST;
			delim_length_q <= DELIM_LENGTH_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DELIM_VALUE:  delim_value_q  <= cfg_data;
				REG_DELIM_LENGTH: delim_length_q <= cfg_data[DLEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept = s_tvalid && s_tready;

	dss_window #(
		.MAX_DELIM_LEN(MAX_DELIM_LEN)
	) u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (s_tdata),
		.has_byte     (s_tuser),
		.stream_last  (s_tlast),
		.delim_value  (delim_value_q),
		.delim_length (delim_length_q),
		.job_bytes    (job_bytes),
		.job_nb       (job_nb),
		.job          (job)
	);

	dss_emit #(
		.MAX_DELIM_LEN(MAX_DELIM_LEN)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept && job.nonempty),
		.in_bytes (job_bytes),
		.in_nb    (job_nb),
		.in_job   (job),
		.ready    (s_tready),
		.m_valid  (m_tvalid),
		.m_ready  (m_tready),
		.m_res    (res)
	);

	assign m_tdata = {res.delimiters_seen, res.bytes_returned, res.pieces_returned,
		res.out_byte};
	assign m_tuser = res.byte_valid;
	assign m_tlast = res.piece_end;

endmodule

`default_nettype wire

[hw/rtl/dss_window.sv]
// Pending window and match logic of the delimiter stream splitter.
// Decodes one input transaction into a byte list and piece-end flags.
// Depends on dss_pkg.
`default_nettype none

module dss_window import dss_pkg::*; #(
	parameter int MAX_DELIM_LEN = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   accept,
	input  wire logic [7:0]             data_byte,
	input  wire logic                   has_byte,
	input  wire logic                   stream_last,
	input  wire logic [CFG_DATA_W-1:0]  delim_value,
	input  wire logic [DLEN_W-1:0]      delim_length,
	output logic [7:0]                  job_bytes [MAX_DELIM_LEN],
	output logic [$clog2(MAX_DELIM_LEN+1)-1:0] job_nb,
	output dss_job_t                    job
);

	localparam int CNT_W  = $clog2(MAX_DELIM_LEN + 1);
	localparam int IDX_W  = (MAX_DELIM_LEN > 1) ? $clog2(MAX_DELIM_LEN) : 1;
	localparam int DEXT_W = 8 * ((MAX_DELIM_LEN > 8) ? MAX_DELIM_LEN : 8);

	logic [7:0]       win_q [MAX_DELIM_LEN];
	logic [CNT_W-1:0] cnt_q;

	logic [7:0]        w     [MAX_DELIM_LEN];
	logic [7:0]        shf   [MAX_DELIM_LEN];
	logic [7:0]        win_d [MAX_DELIM_LEN];
	logic [CNT_W-1:0]  len;
	logic [CNT_W-1:0]  n;
	logic [CNT_W-1:0]  rel;
	logic [CNT_W-1:0]  nb;
	logic [CNT_W-1:0]  cnt_d;
	logic [DEXT_W-1:0] dext;
	logic              full;
	logic              match;

	assign dext = DEXT_W'(delim_value);

	always_comb begin
		if (delim_length == '0) begin
			len = CNT_W'(1);
		end else if (32'(delim_length) > MAX_DELIM_LEN) begin
			len = CNT_W'(MAX_DELIM_LEN);
		end else begin
			len = CNT_W'(delim_length);
		end
	end

	assign n    = cnt_q + CNT_W'(has_byte);
	assign full = has_byte && (n >= len);
	// bytes pushed past the delimiter length go out before the compare
	assign rel  = (has_byte && (n > len)) ? (n - len) : '0;

	always_comb begin
		logic [CNT_W:0] pos;
		for (int i = 0; i < MAX_DELIM_LEN; i++) begin
			w[i] = (CNT_W'(i) < cnt_q) ? win_q[i] : data_byte;
		end
		match = full;
		for (int i = 0; i < MAX_DELIM_LEN; i++) begin
			pos    = (CNT_W+1)'(rel) + (CNT_W+1)'(i);
			shf[i] = (pos < (CNT_W+1)'(MAX_DELIM_LEN)) ? w[pos[IDX_W-1:0]] : 8'd0;
			if ((CNT_W'(i) < len) && (shf[i] != dext[i*8 +: 8])) begin
				match = 1'b0;
			end
		end
	end

	always_comb begin
		if (match) begin
			nb = rel;
		end else if (stream_last) begin
			nb = n;
		end else if (full) begin
			nb = rel + CNT_W'(1);
		end else begin
			nb = '0;
		end
	end

	// surviving window: drop the released bytes from the front
	always_comb begin
		logic [CNT_W:0] pos;
		for (int i = 0; i < MAX_DELIM_LEN; i++) begin
			pos      = (CNT_W+1)'(nb) + (CNT_W+1)'(i);
			win_d[i] = (pos < (CNT_W+1)'(MAX_DELIM_LEN)) ? w[pos[IDX_W-1:0]] : 8'd0;
		end
		cnt_d = (match || stream_last) ? '0 : (n - nb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_q <= win_d;
		end
	end

	assign job_bytes    = w;
	assign job_nb       = nb;
	assign job.match    = match;
	assign job.last     = stream_last;
	assign job.nonempty = (nb != '0) || match || stream_last;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) < MAX_DELIM_LEN)
		else $error("pending count reached the window depth");

	a_last_flush: assert property (@(posedge clk) disable iff (!arst_n)
		accept && stream_last |=> cnt_q == '0)
		else $error("window not empty after end of stream");

	a_match_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && match |=> cnt_q == '0)
		else $error("window not cleared after delimiter match");

endmodule

`default_nettype wire

[hw/rtl/dss_emit.sv]
// Result sequencer of the delimiter stream splitter: holds one decoded transaction,
// sends its results one per cycle unless m_ready stalls them, and keeps the running counters.
// Depends on dss_pkg.
`default_nettype none

module dss_emit import dss_pkg::*; #(
	parameter int MAX_DELIM_LEN = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load,
	input  wire logic [7:0]             in_bytes [MAX_DELIM_LEN],
	input  wire logic [$clog2(MAX_DELIM_LEN+1)-1:0] in_nb,
	input  wire dss_job_t               in_job,
	output logic                        ready,
	output logic                        m_valid,
	input  wire logic                   m_ready,
	output dss_res_t                    m_res
);

	localparam int CNT_W = $clog2(MAX_DELIM_LEN + 1);
	localparam int IDX_W = (MAX_DELIM_LEN > 1) ? $clog2(MAX_DELIM_LEN) : 1;
	localparam int POS_W = $clog2(MAX_DELIM_LEN + 3);

	logic [7:0]         job_bytes_s1 [MAX_DELIM_LEN];
	logic [CNT_W-1:0]   job_nb_s1;
	dss_job_t           job_s1;
	logic               job_valid_q;
	logic [POS_W-1:0]   idx_q;
	logic [CNT32_W-1:0] pieces_q;
	logic [CNT32_W-1:0] bytes_q;
	logic [CNT32_W-1:0] delims_q;
	logic               m_valid_q;
	dss_res_t           res_q;

	logic [POS_W-1:0] tot;
	logic             out_free;
	logic             emit;
	logic             done;
	logic             is_byte;
	logic             is_match_end;
	dss_res_t         res_d;

	assign tot = POS_W'(job_nb_s1) + POS_W'(job_s1.match) + POS_W'(job_s1.last);
	assign out_free     = !m_valid_q || m_ready;
	assign emit         = job_valid_q && out_free;
	assign done         = emit && (idx_q == tot - POS_W'(1));
	assign ready        = !job_valid_q || done;
	assign is_byte      = idx_q < POS_W'(job_nb_s1);
	assign is_match_end = !is_byte && job_s1.match && (idx_q == POS_W'(job_nb_s1));

	always_comb begin
		res_d.out_byte        = is_byte ? job_bytes_s1[idx_q[IDX_W-1:0]] : 8'd0;
		res_d.byte_valid      = is_byte;
		res_d.piece_end       = !is_byte;
		res_d.pieces_returned = pieces_q + CNT32_W'(!is_byte);
		res_d.bytes_returned  = bytes_q + CNT32_W'(is_byte);
		res_d.delimiters_seen = delims_q + CNT32_W'(is_match_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
			pieces_q    <= '0;
			bytes_q     <= '0;
			delims_q    <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if (load) begin
				job_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (done) begin
				job_valid_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + POS_W'(1);
			end
			if (emit) begin
				pieces_q  <= res_d.pieces_returned;
				bytes_q   <= res_d.bytes_returned;
				delims_q  <= res_d.delimiters_seen;
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_bytes_s1 <= in_bytes;
			job_nb_s1    <= in_nb;
			job_s1       <= in_job;
		end
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign m_valid = m_valid_q;
	assign m_res   = res_q;

	a_job_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q |-> tot != '0)
		else $error("held transaction has no results");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q |-> idx_q < tot)
		else $error("result index ran past the transaction");

	a_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		emit && is_byte |=> bytes_q == $past(bytes_q) + CNT32_W'(1))
		else $error("byte counter did not advance on a byte result");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !job_valid_q || done)
		else $error("new transaction loaded over a busy one");

endmodule

`default_nettype wire
